// ----- rtl/srlf_pkg.sv -----
`default_nettype none
package srlf_pkg;

  localparam int ROW_PIXELS_DEF = 640;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_CENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIFT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_LIMIT    = 3'd5;

  localparam logic [7:0] BLACK_LEVEL_RST     = 8'd100;
  localparam logic [7:0] COLOR_TOLERANCE_RST = 8'd25;
  localparam logic [9:0] MIN_RUN_RST         = 10'd10;
  localparam logic [9:0] IMAGE_CENTER_RST    = 10'd320;
  localparam logic [9:0] MAX_DRIFT_RST       = 10'd150;
  localparam logic [9:0] NARROW_LIMIT_RST    = 10'd25;

  localparam int STEP = 3;

  typedef enum logic [2:0] {
    RD_I,
    RD_I3,
    RD_OLD,
    RD_RIGHT,
    RD_LEFT
  } srlf_rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_RD_WT,
    ST_A_NEXT,
    ST_A_RUN_CHK,
    ST_A_RUN_WT,
    ST_A_EVAL,
    ST_T_OLD,
    ST_T_OLD_WT,
    ST_T_R_CHK,
    ST_T_R_WT,
    ST_T_L_CHK,
    ST_T_L_WT,
    ST_T_EVAL,
    ST_FIN,
    ST_OUTW
  } srlf_state_t;

  typedef struct packed {
    logic         accept;
    logic         search_init;
    logic         rd_start;
    srlf_rd_sel_t rd_sel;
    logic         start_set;
    logic         i_inc1;
    logic         i_inc3;
    logic         a_eval;
    logic         track_init;
    logic         right_inc;
    logic         left_dec;
    logic         t_eval;
    logic         fin;
    logic         out_load;
  } srlf_cmd_t;

  typedef struct packed {
    logic tracking;
    logic rd_done;
    logic rd_bit;
    logic rd_many;
    logic i_last;
    logic i_room;
    logic r_room;
    logic l_room;
  } srlf_sts_t;

endpackage
`default_nettype wire

// ----- rtl/srlf_dp.sv -----
`default_nettype none
module srlf_dp #(
  parameter int ROW_PIXELS = srlf_pkg::ROW_PIXELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [srlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srlf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [srlf_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tuser,
  output logic      [srlf_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  wire srlf_pkg::srlf_cmd_t               cmd,
  output srlf_pkg::srlf_sts_t                    sts
);

  localparam int IW = $clog2(ROW_PIXELS);
  localparam int CW = $clog2(ROW_PIXELS + 1);
  localparam int PW = IW + 2;
  localparam int WW = (PW > 12) ? PW : 12;
  localparam logic signed [PW-1:0] MINUS1 = '1;
  localparam logic signed [WW-1:0] P_W = WW'(ROW_PIXELS);
  localparam logic signed [WW-1:0] STEP_W = WW'(srlf_pkg::STEP);

  function automatic logic [8:0] mag9(input logic signed [8:0] v);
    mag9 = (v < 0) ? 9'(-v) : 9'(v);
  endfunction

  function automatic logic signed [WW-1:0] magw(input logic signed [WW-1:0] v);
    magw = (v < 0) ? -v : v;
  endfunction

  // configuration
  logic [7:0] black_level, color_tolerance;
  logic [9:0] min_run, image_center, max_drift, narrow_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_level     <= srlf_pkg::BLACK_LEVEL_RST;
      color_tolerance <= srlf_pkg::COLOR_TOLERANCE_RST;
      min_run         <= srlf_pkg::MIN_RUN_RST;
      image_center    <= srlf_pkg::IMAGE_CENTER_RST;
      max_drift       <= srlf_pkg::MAX_DRIFT_RST;
      narrow_limit    <= srlf_pkg::NARROW_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srlf_pkg::REG_BLACK_LEVEL:     black_level <= cfg_data[7:0];
        srlf_pkg::REG_COLOR_TOLERANCE: color_tolerance <= cfg_data[7:0];
        srlf_pkg::REG_MIN_RUN:         min_run <= cfg_data;
        srlf_pkg::REG_IMAGE_CENTER:    image_center <= cfg_data;
        srlf_pkg::REG_MAX_DRIFT:       max_drift <= cfg_data;
        srlf_pkg::REG_NARROW_LIMIT:    narrow_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel classification
  logic [7:0] blue, green, red;
  logic [9:0] row_index;
  logic signed [8:0] d_bg, d_br, d_rg;
  logic [8:0] tol9;
  logic black;

  assign blue      = s_tdata[7:0];
  assign green     = s_tdata[15:8];
  assign red       = s_tdata[23:16];
  assign row_index = s_tdata[33:24];
  assign d_bg = $signed({1'b0, blue}) - $signed({1'b0, green});
  assign d_br = $signed({1'b0, blue}) - $signed({1'b0, red});
  assign d_rg = $signed({1'b0, red}) - $signed({1'b0, green});
  assign tol9 = {1'b0, color_tolerance};
  assign black = (blue <= black_level) && (mag9(d_bg) < tol9) && (mag9(d_br) < tol9) &&
                 (mag9(d_rg) < tol9);

  logic [CW-1:0] pix_cnt, cnt_eff;
  logic          map_we;

  assign cnt_eff = s_tuser ? '0 : pix_cnt;
  assign map_we  = cmd.accept && (cnt_eff < CW'(ROW_PIXELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
    end else if (cmd.accept) begin
      if (cmd.search_init) pix_cnt <= '0;
      else if (map_we)     pix_cnt <= cnt_eff + 1'b1;
      else                 pix_cnt <= cnt_eff;
    end
  end

  // map read unit: one entry per cycle, a request of one or three entries
  logic                 black_map [ROW_PIXELS];
  logic signed [PW-1:0] rd_base, rd_pos, rd_off;
  logic                 rd_back, rd_busy, rd_q, rd_ok_q, rd_issue, rd_inrange, rd_bitv;
  logic [1:0]           rd_n, rd_step, rd_acc, rd_sum;
  logic [IW-1:0]        rd_idx;

  logic signed [PW-1:0] i_pos, start_pos, right_pos, left_pos;
  logic signed [PW-1:0] center, width, tracked, first_c;

  assign rd_off     = $signed(PW'(rd_step));
  assign rd_pos     = rd_back ? rd_base - rd_off : rd_base + rd_off;
  assign rd_inrange = (rd_pos >= 0) && (WW'(rd_pos) < P_W);
  assign rd_idx     = rd_pos[IW-1:0];
  assign rd_issue   = rd_busy && (rd_step != rd_n);
  assign rd_bitv    = rd_q & rd_ok_q;
  assign rd_sum     = rd_acc + 2'(rd_bitv);

  always_ff @(posedge clk) begin
    if (map_we) black_map[cnt_eff[IW-1:0]] <= black;
    rd_q <= black_map[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= rd_issue && rd_inrange;
      if (cmd.rd_start) begin
        rd_busy <= 1'b1;
        rd_step <= '0;
        rd_acc  <= '0;
        unique case (cmd.rd_sel)
          srlf_pkg::RD_I: begin
            rd_base <= i_pos; rd_back <= 1'b0; rd_n <= 2'd1;
          end
          srlf_pkg::RD_I3: begin
            rd_base <= PW'(WW'(i_pos) + STEP_W); rd_back <= 1'b0; rd_n <= 2'd3;
          end
          srlf_pkg::RD_OLD: begin
            rd_base <= tracked; rd_back <= 1'b0; rd_n <= 2'd1;
          end
          srlf_pkg::RD_RIGHT: begin
            rd_base <= right_pos; rd_back <= 1'b0; rd_n <= 2'd3;
          end
          srlf_pkg::RD_LEFT: begin
            rd_base <= left_pos; rd_back <= 1'b1; rd_n <= 2'd3;
          end
          default: begin
            rd_base <= i_pos; rd_back <= 1'b0; rd_n <= 2'd1;
          end
        endcase
      end else if (rd_busy) begin
        if (rd_step != 2'd0) rd_acc <= rd_sum;
        if (rd_step == rd_n) rd_busy <= 1'b0;
        else                 rd_step <= rd_step + 2'd1;
      end
    end
  end

  // search arithmetic
  logic signed [WW-1:0] iw, sw, rw, lw, cw, fw, fe, ic, span, ca, wt, ww_;
  logic                 drift;

  assign iw   = WW'(i_pos);
  assign sw   = WW'(start_pos);
  assign rw   = WW'(right_pos);
  assign lw   = WW'(left_pos);
  assign cw   = WW'(center);
  assign fw   = WW'(first_c);
  assign fe   = (first_c == MINUS1) ? cw : fw;
  assign ic   = $signed(WW'(image_center));
  assign span = iw - sw;
  assign ca   = (iw + sw) >>> 1;
  assign wt   = rw - lw;
  assign ww_  = WW'(width);
  assign drift = magw(cw - fe) > $signed(WW'(max_drift));

  logic [9:0]         max_w, min_w;
  logic signed [10:0] max_row, min_center;
  logic [9:0]         row_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked    <= MINUS1;
      first_c    <= MINUS1;
      max_w      <= '0;
      max_row    <= '1;
      min_w      <= '0;
      min_center <= '1;
    end else begin
      if (cmd.accept && s_tuser) begin
        first_c <= MINUS1;
        max_w   <= '0;
        min_w   <= '0;
      end
      if (cmd.search_init) begin
        center <= MINUS1;
        width  <= MINUS1;
        i_pos  <= '0;
        row_q  <= row_index;
      end
      if (cmd.start_set) start_pos <= i_pos;
      if (cmd.i_inc1) i_pos <= i_pos + 1'b1;
      if (cmd.i_inc3) i_pos <= PW'(iw + STEP_W);
      if (cmd.a_eval && (span >= $signed(WW'(min_run))) &&
          (magw(ic - ca) < magw(ic - cw))) begin
        center <= PW'(ca);
        width  <= PW'(span);
      end
      if (cmd.track_init) begin
        right_pos <= tracked + 1'b1;
        left_pos  <= tracked - 1'b1;
      end
      if (cmd.right_inc) right_pos <= PW'(rw + STEP_W);
      if (cmd.left_dec)  left_pos  <= PW'(lw - STEP_W);
      // a line that fails the narrow test keeps center at -1 and is dropped in fin
      if (cmd.t_eval && (magw(wt - lw) >= $signed(WW'(narrow_limit)))) begin
        center <= PW'((lw + rw) >>> 1);
        width  <= PW'(wt);
      end
      if (cmd.fin) begin
        if (center != MINUS1) begin
          first_c <= PW'(fe);
          if (drift) begin
            center  <= MINUS1;
            width   <= MINUS1;
            tracked <= MINUS1;
          end else begin
            tracked <= center;
            if (($signed(WW'(max_w)) < ww_) || (max_w == '0)) begin
              max_w   <= 10'(width);
              max_row <= $signed({1'b0, row_q});
            end
            if (($signed(WW'(min_w)) > ww_) || (min_w == '0)) begin
              min_w      <= 10'(width);
              min_center <= 11'(center);
            end
          end
        end else begin
          tracked <= MINUS1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'b0, min_center, min_w, max_row, max_w, 11'(first_c), 11'(width),
                  11'(center)};
    end
  end

  assign sts.tracking = (tracked != MINUS1);
  assign sts.rd_done  = rd_busy && (rd_step == rd_n);
  assign sts.rd_bit   = (rd_sum != 2'd0);
  assign sts.rd_many  = (rd_sum > 2'd1);
  assign sts.i_last   = (iw == P_W - 1);
  assign sts.i_room   = (iw + STEP_W < P_W);
  assign sts.r_room   = (rw + STEP_W < P_W);
  assign sts.l_room   = (lw >= STEP_W);

endmodule
`default_nettype wire

// ----- rtl/srlf_ctrl.sv -----
`default_nettype none
module srlf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_tlast,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire srlf_pkg::srlf_sts_t sts,
  output srlf_pkg::srlf_cmd_t      cmd
);

  srlf_pkg::srlf_state_t state, state_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srlf_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)    m_tvalid <= 1'b1;
      else if (m_tready)   m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srlf_pkg::ST_IDLE:
        if (s_tvalid && s_tlast)
          state_next = sts.tracking ? srlf_pkg::ST_T_OLD : srlf_pkg::ST_A_RD;
      srlf_pkg::ST_A_RD:    state_next = srlf_pkg::ST_A_RD_WT;
      srlf_pkg::ST_A_RD_WT:
        if (sts.rd_done)
          state_next = sts.rd_bit ? srlf_pkg::ST_A_RUN_CHK : srlf_pkg::ST_A_NEXT;
      srlf_pkg::ST_A_NEXT:
        state_next = sts.i_last ? srlf_pkg::ST_FIN : srlf_pkg::ST_A_RD;
      srlf_pkg::ST_A_RUN_CHK:
        state_next = sts.i_room ? srlf_pkg::ST_A_RUN_WT : srlf_pkg::ST_A_EVAL;
      srlf_pkg::ST_A_RUN_WT:
        if (sts.rd_done)
          state_next = sts.rd_many ? srlf_pkg::ST_A_RUN_CHK : srlf_pkg::ST_A_EVAL;
      srlf_pkg::ST_A_EVAL:  state_next = srlf_pkg::ST_A_NEXT;
      srlf_pkg::ST_T_OLD:   state_next = srlf_pkg::ST_T_OLD_WT;
      srlf_pkg::ST_T_OLD_WT:
        if (sts.rd_done)
          state_next = sts.rd_bit ? srlf_pkg::ST_T_R_CHK : srlf_pkg::ST_FIN;
      srlf_pkg::ST_T_R_CHK:
        state_next = sts.r_room ? srlf_pkg::ST_T_R_WT : srlf_pkg::ST_T_L_CHK;
      srlf_pkg::ST_T_R_WT:
        if (sts.rd_done)
          state_next = sts.rd_many ? srlf_pkg::ST_T_R_CHK : srlf_pkg::ST_T_L_CHK;
      srlf_pkg::ST_T_L_CHK:
        state_next = sts.l_room ? srlf_pkg::ST_T_L_WT : srlf_pkg::ST_T_EVAL;
      srlf_pkg::ST_T_L_WT:
        if (sts.rd_done)
          state_next = sts.rd_many ? srlf_pkg::ST_T_L_CHK : srlf_pkg::ST_T_EVAL;
      srlf_pkg::ST_T_EVAL:  state_next = srlf_pkg::ST_FIN;
      srlf_pkg::ST_FIN:     state_next = srlf_pkg::ST_OUTW;
      srlf_pkg::ST_OUTW:
        if (out_free) state_next = srlf_pkg::ST_IDLE;
      default:              state_next = srlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      srlf_pkg::ST_IDLE: begin
        s_tready        = 1'b1;
        cmd.accept      = s_tvalid;
        cmd.search_init = s_tvalid && s_tlast;
      end
      srlf_pkg::ST_A_RD: begin
        cmd.rd_start = 1'b1;
        cmd.rd_sel   = srlf_pkg::RD_I;
      end
      srlf_pkg::ST_A_RD_WT:
        cmd.start_set = sts.rd_done && sts.rd_bit;
      srlf_pkg::ST_A_NEXT:
        cmd.i_inc1 = !sts.i_last;
      srlf_pkg::ST_A_RUN_CHK: begin
        cmd.rd_start = sts.i_room;
        cmd.i_inc3   = sts.i_room;
        cmd.rd_sel   = srlf_pkg::RD_I3;
      end
      srlf_pkg::ST_A_EVAL:
        cmd.a_eval = 1'b1;
      srlf_pkg::ST_T_OLD: begin
        cmd.rd_start = 1'b1;
        cmd.rd_sel   = srlf_pkg::RD_OLD;
      end
      srlf_pkg::ST_T_OLD_WT:
        cmd.track_init = sts.rd_done && sts.rd_bit;
      srlf_pkg::ST_T_R_CHK: begin
        cmd.rd_start = sts.r_room;
        cmd.rd_sel   = srlf_pkg::RD_RIGHT;
      end
      srlf_pkg::ST_T_R_WT:
        cmd.right_inc = sts.rd_done && sts.rd_many;
      srlf_pkg::ST_T_L_CHK: begin
        cmd.rd_start = sts.l_room;
        cmd.rd_sel   = srlf_pkg::RD_LEFT;
      end
      srlf_pkg::ST_T_L_WT:
        cmd.left_dec = sts.rd_done && sts.rd_many;
      srlf_pkg::ST_T_EVAL:
        cmd.t_eval = 1'b1;
      srlf_pkg::ST_FIN:
        cmd.fin = 1'b1;
      srlf_pkg::ST_OUTW:
        cmd.out_load = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.rd_done |-> (state == srlf_pkg::ST_A_RD_WT || state == srlf_pkg::ST_A_RUN_WT ||
                     state == srlf_pkg::ST_T_OLD_WT || state == srlf_pkg::ST_T_R_WT ||
                     state == srlf_pkg::ST_T_L_WT)) else $error("stray read done");
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready) else $error("took request in search");
  a_valid_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid) else $error("result lost");
`endif

endmodule
`default_nettype wire

// ----- rtl/scan_row_line_finder_unit.sv -----
`default_nettype none
// Pixels are taken one per cycle; a request without tlast gives no result.
// Row end search reads the black map once per cycle through a registered port:
// acquiring reads one column at a time outside a run and three at a time inside
// one; tracking walks three columns at a time each way from the old center.
// Input is held off during the search; one finished result may wait at the output.
// Synchronous reset restores the registers and statistics; the map has no clearing pass.
module scan_row_line_finder_unit #(
  parameter int ROW_PIXELS = srlf_pkg::ROW_PIXELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srlf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // blue[7:0], green[15:8], red[23:16], row_index[33:24], zero fill above
  input  wire logic [srlf_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  // frame_start
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // line_center, line_width, first_center, widest_width, widest_row,
  // narrowest_width, narrowest_center, zero fill above
  output logic      [srlf_pkg::OUT_DATA_W-1:0] m_tdata
);

  srlf_pkg::srlf_cmd_t cmd;
  srlf_pkg::srlf_sts_t sts;

  assign cfg_ready = 1'b1;

  srlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srlf_dp #(
    .ROW_PIXELS (ROW_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
module testbench;
  import srlf_pkg::*;

  localparam int RP = ROW_PIXELS_DEF;
  localparam int WATCHDOG = 20000;

  // Row-end line search predictor; holds the black map, tracking and frame statistics
  class row_scoreboard;
    int black_level, tolerance, min_run, img_center, max_drift, narrow_lim;
    bit map_bit [RP];
    int pix_cnt, tracked, first_c, max_w, max_w_row, min_w, min_w_c;
    logic [OUT_DATA_W-1:0] line_q [$];
    int errors, results;

    function void init();
      black_level = BLACK_LEVEL_RST; tolerance = COLOR_TOLERANCE_RST;
      min_run = MIN_RUN_RST; img_center = IMAGE_CENTER_RST;
      max_drift = MAX_DRIFT_RST; narrow_lim = NARROW_LIMIT_RST;
      pix_cnt = 0; tracked = -1; first_c = -1;
      max_w = 0; max_w_row = -1; min_w = 0; min_w_c = -1;
      errors = 0; results = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int v);
      case (idx)
        REG_BLACK_LEVEL:     black_level = v & 8'hff;
        REG_COLOR_TOLERANCE: tolerance = v & 8'hff;
        REG_MIN_RUN:         min_run = v & 10'h3ff;
        REG_IMAGE_CENTER:    img_center = v & 10'h3ff;
        REG_MAX_DRIFT:       max_drift = v & 10'h3ff;
        REG_NARROW_LIMIT:    narrow_lim = v & 10'h3ff;
        default: ;
      endcase
    endfunction

    function int mag(int v);
      return v < 0 ? -v : v;
    endfunction

    function int bk(int i);
      if (i < 0 || i >= RP) return 0;
      return map_bit[i];
    endfunction

    function void note_pixel(int b, int g, int r, int row, bit last, bit fs);
      int c, w, ic, i, st, cnt, old, right, left, m;
      bit lost;
      c = -1; w = -1;
      if (fs) begin
        first_c = -1; max_w = 0; min_w = 0; pix_cnt = 0;
      end
      if (pix_cnt < RP) begin
        map_bit[pix_cnt] = b <= black_level && mag(b - g) < tolerance &&
                           mag(b - r) < tolerance && mag(r - g) < tolerance;
        pix_cnt++;
      end
      if (!last) return;
      pix_cnt = 0;
      if (tracked == -1) begin
        ic = img_center;
        for (i = 0; i < RP; i++) begin
          if (bk(i)) begin
            st = i; cnt = 3;
            while (cnt > 1 && i + 3 < RP) begin
              i += 3;
              cnt = bk(i) + bk(i + 1) + bk(i + 2);
            end
            if (i - st >= min_run) begin
              m = (i + st) / 2;
              if (mag(ic - m) < mag(ic - c)) begin
                c = m; w = i - st;
              end
            end
          end
        end
      end else begin
        old = tracked;
        lost = 1;
        if (old >= 0 && old < RP && bk(old)) begin
          for (right = old + 1; right + 3 < RP; right += 3)
            if (bk(right) + bk(right + 1) + bk(right + 2) <= 1) break;
          for (left = old - 1; left >= 3; left -= 3)
            if (bk(left) + bk(left - 1) + bk(left - 2) <= 1) break;
          c = (left + right) / 2;
          w = right - left;
          if (mag(w - left) >= narrow_lim) lost = 0;
        end
        if (lost) begin
          c = -1; w = -1; tracked = -1;
        end
      end
      if (tracked != -1 || c != -1) begin
        if (first_c == -1 && c != -1) first_c = c;
        if (c != -1 && mag(c - first_c) > max_drift) begin
          c = -1; w = -1;
        end
        if (c != -1) begin
          if (max_w < w || max_w == 0) begin
            max_w = w; max_w_row = row;
          end
          if (min_w > w || min_w == 0) begin
            min_w = w; min_w_c = c;
          end
        end
        tracked = c;
      end
      line_q.push_back({5'b0, 11'(min_w_c), 10'(min_w), 11'(max_w_row), 10'(max_w),
                        11'(first_c), 11'(w), 11'(c)});
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] got);
      int offs [7] = '{0, 11, 22, 33, 43, 54, 64};
      int wids [7] = '{11, 11, 11, 10, 11, 10, 11};
      string names [7] = '{"line_center", "line_width", "first_center", "widest_width",
                           "widest_row", "narrowest_width", "narrowest_center"};
      logic [OUT_DATA_W-1:0] want, mask;
      results++;
      if (line_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = line_q.pop_front();
      for (int k = 0; k < 7; k++) begin
        mask = (80'd1 << wids[k]) - 1;
        if (((want >> offs[k]) & mask) !== ((got >> offs[k]) & mask)) begin
          $display("%0t: %s expected %0h actual %0h", $realtime, names[k],
                   (want >> offs[k]) & mask, (got >> offs[k]) & mask);
          errors++;
        end
      end
    endfunction

    function int pending();
      return line_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic s_tvalid, s_tready, s_tlast, s_tuser;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  row_scoreboard sb;
  int pixels_sent;
  int phase_base;
  bit burst;
  bit hold_done;

  scan_row_line_finder_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic send_pixel(int b, int g, int r, int row, bit last, bit fs);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, 10'(row), 8'(r), 8'(g), 8'(b)};
    s_tlast <= last;
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(b, g, r, row, last, fs);
    pixels_sent++;
  endtask

  function automatic int clip(int v);
    return v > 255 ? 255 : v;
  endfunction

  // one row: a dark run of grey pixels over random background, or pure noise
  task automatic send_row(int len, int run_s, int run_w, bit fs, bit noise);
    int row, v, n, b, g, r, fs_at;
    row = $urandom_range(0, 1023);
    burst = $urandom_range(0, 3) == 0;
    fs_at = fs ? ($urandom_range(0, 4) == 0 ? $urandom_range(0, len - 1) : 0) : -1;
    for (int i = 0; i < len; i++) begin
      if (!noise && i >= run_s && i < run_s + run_w) begin
        v = $urandom_range(0, sb.black_level);
        n = sb.tolerance > 1 ? (sb.tolerance - 1) / 2 : 0;
        b = v; g = clip(v + $urandom_range(0, n)); r = clip(v + $urandom_range(0, n));
      end else begin
        b = $urandom_range(0, 255); g = $urandom_range(0, 255); r = $urandom_range(0, 255);
      end
      send_pixel(b, g, r, row, i == len - 1, i == fs_at);
    end
  endtask

  task automatic random_row();
    int len, k, s;
    k = $urandom_range(0, 99);
    if (k < 80) len = $urandom_range(1, 20);
    else if (k < 97) len = $urandom_range(21, 80);
    else len = $urandom_range(81, 200);
    s = $urandom_range(0, len - 1);
    send_row(len, s, $urandom_range(1, 90), $urandom_range(0, 9) == 0,
             $urandom_range(0, 4) == 0);
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_all(int bl, int tol, int mr, int ic, int md, int nl);
    write_reg(REG_BLACK_LEVEL, bl);
    write_reg(REG_COLOR_TOLERANCE, tol);
    write_reg(REG_MIN_RUN, mr);
    write_reg(REG_IMAGE_CENTER, ic);
    write_reg(REG_MAX_DRIFT, md);
    write_reg(REG_NARROW_LIMIT, nl);
    cfg_valid <= 0;
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    m_tready = 0;
    @(negedge rst);
    forever begin
      if (!hold_done && sb.results == 6) begin
        hold_done = 1;
        stall = 3000;
      end else begin
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("scan_row_line_finder_unit verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.init();
    rst = 1;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0; s_tuser = 0;
    pixels_sent = 0; phase_base = 0; burst = 0; hold_done = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // first row overruns and fills the whole map; then tracking on short rows,
    // same-step frame start
    send_row(RP + 5, 300, 40, 0, 0);
    send_row(20, 0, 20, 1, 0);
    send_pixel(255, 0, 255, 1023, 0, 0);
    send_pixel(0, 255, 0, 0, 0, 0);
    send_pixel(0, 0, 0, 512, 1, 1);
    send_row(12, 0, 12, 0, 0);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: write_all(0, 0, 0, 0, 0, 0);
        2: write_all(255, 255, 639, 639, 639, 639);
        3: write_all(255, 255, 0, 0, 0, 0);
        4: write_all(120, 40, 3, 100, 639, 0);
        5: write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 60),
                     $urandom_range(0, 639), $urandom_range(0, 639), $urandom_range(0, 60));
        default: write_all(100, 25, 10, 320, 150, 25);
      endcase
      phase_base = pixels_sent;
      while (pixels_sent < phase_base + 80)
        random_row();
      settle();
    end

    if (sb.errors == 0)
      $display("scan_row_line_finder_unit verification clean");
    else
      $display("scan_row_line_finder_unit verification failed");
    $finish;
  end
endmodule
